### rtl/pfu_pkg.sv
// Shared constants for the prime factorizer unit.
package pfu_pkg;

  // Width of the value and factor fields on the channels
  localparam int unsigned FIELD_BITS = 31;

  // Most results emitted for one input word
  localparam int unsigned RESULT_CAP = 30;
  localparam int unsigned COUNT_BITS = $clog2(RESULT_CAP + 1);

  // Trial division starts at the smallest prime
  localparam int unsigned FIRST_PRIME = 2;

  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [COUNT_BITS-1:0] count_t;

endpackage

### rtl/pfu_if.sv
// Valid/ready channel interfaces for the input value and the factor results.
interface pfu_in_if
  import pfu_pkg::*;
;
  logic   valid;
  logic   ready;
  field_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface pfu_out_if
  import pfu_pkg::*;
;
  logic   valid;
  logic   ready;
  field_t factor;
  logic   last;
  logic   none;

  modport source (output valid, output factor, output last, output none, input ready);
  modport sink   (input valid, input factor, input last, input none, output ready);
endinterface

### rtl/prime_factorizer_unit.sv
// Prime factorizer: trial division over one shared restoring divider.
//
// Takes one non-negative value word and returns its prime factors in ascending order, one
// word per factor, repeated by multiplicity, with last set on the final word. Zero gives one
// word with factor 0 and none set; one gives a single word with factor 1. The block handles
// one value at a time and drops in_ready until its last factor is in the output register.
// Each trial divisor takes VALUE_BITS steps of the bit-serial divider (one compare and
// subtract a cycle) and then an evaluation of quotient and remainder; every factor found
// is handed on and followed by a further divide by the same divisor. The divider therefore
// sets the rate: roughly sqrt(value) - 1 trial divisors for a prime, and far fewer for values
// with only small factors. Stalls on out_ready add to this.
module prime_factorizer_unit
  import pfu_pkg::*;
#(
  parameter int unsigned VALUE_BITS = 31
) (
  input  logic      clk,
  input  logic      rst_n,
  pfu_in_if.sink    in_chan,
  pfu_out_if.source out_chan
);

  localparam int unsigned W      = VALUE_BITS;
  localparam int unsigned STEP_W = $clog2(W);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_EVAL  = 3'd2;
  localparam logic [2:0] ST_PUSH  = 3'd3;
  localparam logic [2:0] ST_TAIL  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [W-1:0]      rest_r, rest_nxt;
  logic [W-1:0]      trial_r, trial_nxt;
  logic [W-1:0]      part_r, part_nxt;     // partial remainder
  logic [W-1:0]      quo_r, quo_nxt;       // dividend in, quotient out
  logic [STEP_W-1:0] step_r, step_nxt;
  count_t            count_r, count_nxt;
  logic [W-1:0]      fac_r, fac_nxt;       // newly found factor
  logic              tail_r, tail_nxt;
  logic [W-1:0]      pend_fac_r, pend_fac_nxt;
  logic              pend_none_r, pend_none_nxt;
  logic              pend_v_r, pend_v_nxt;

  logic              out_valid_r, out_valid_nxt;
  field_t            out_factor_r, out_factor_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_none_r, out_none_nxt;

  logic              slot_free;
  logic [W-1:0]      in_rest;
  logic [W:0]        shifted;
  logic [W:0]        diff;
  logic              fits;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign in_rest   = W'(in_chan.value);

  // Restoring divider step: one compare and subtract
  assign shifted = {part_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, trial_r};
  assign fits    = !diff[W];

  assign in_chan.ready   = (state_r == ST_IDLE);
  assign out_chan.valid  = out_valid_r;
  assign out_chan.factor = out_factor_r;
  assign out_chan.last   = out_last_r;
  assign out_chan.none   = out_none_r;

  always_comb begin
    state_nxt      = state_r;
    rest_nxt       = rest_r;
    trial_nxt      = trial_r;
    part_nxt       = part_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    count_nxt      = count_r;
    fac_nxt        = fac_r;
    tail_nxt       = tail_r;
    pend_fac_nxt   = pend_fac_r;
    pend_none_nxt  = pend_none_r;
    pend_v_nxt     = pend_v_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_factor_nxt = out_factor_r;
    out_last_nxt   = out_last_r;
    out_none_nxt   = out_none_r;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          rest_nxt  = in_rest;
          trial_nxt = W'(FIRST_PRIME);
          count_nxt = '0;
          tail_nxt  = 1'b0;
          if (in_rest == '0 || in_rest == W'(1)) begin
            // zero and one give a single word straight away
            pend_fac_nxt  = in_rest;
            pend_none_nxt = (in_rest == '0);
            pend_v_nxt    = 1'b1;
            count_nxt     = count_t'(1);
            state_nxt     = ST_FLUSH;
          end else begin
            pend_v_nxt = 1'b0;
            part_nxt   = '0;
            quo_nxt    = in_rest;
            step_nxt   = '0;
            state_nxt  = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        part_nxt = fits ? diff[W-1:0] : shifted[W-1:0];
        quo_nxt  = {quo_r[W-2:0], fits};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(W - 1)) begin
          state_nxt = ST_EVAL;
        end
      end

      ST_EVAL: begin
        if (trial_r > quo_r || count_r >= count_t'(RESULT_CAP)) begin
          state_nxt = ST_TAIL;
        end else if (part_r == '0) begin
          fac_nxt   = trial_r;
          rest_nxt  = quo_r;
          state_nxt = ST_PUSH;
        end else begin
          trial_nxt = trial_r + 1'b1;
          part_nxt  = '0;
          quo_nxt   = rest_r;
          step_nxt  = '0;
          state_nxt = ST_DIV;
        end
      end

      ST_PUSH: begin
        // hand the held factor on once the output register is free, hold the new one
        if (!pend_v_r || slot_free) begin
          if (pend_v_r) begin
            out_valid_nxt  = 1'b1;
            out_factor_nxt = FIELD_BITS'(pend_fac_r);
            out_last_nxt   = 1'b0;
            out_none_nxt   = pend_none_r;
          end
          pend_fac_nxt  = fac_r;
          pend_none_nxt = 1'b0;
          pend_v_nxt    = 1'b1;
          count_nxt     = count_r + 1'b1;
          if (tail_r) begin
            state_nxt = ST_FLUSH;
          end else begin
            part_nxt  = '0;
            quo_nxt   = rest_r;
            step_nxt  = '0;
            state_nxt = ST_DIV;
          end
        end
      end

      ST_TAIL: begin
        // a remainder above one is itself prime
        if (rest_r > W'(1) && count_r < count_t'(RESULT_CAP)) begin
          fac_nxt   = rest_r;
          tail_nxt  = 1'b1;
          state_nxt = ST_PUSH;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_factor_nxt = FIELD_BITS'(pend_fac_r);
          out_last_nxt   = 1'b1;
          out_none_nxt   = pend_none_r;
          pend_v_nxt     = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      tail_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rest_r       <= rest_nxt;
    trial_r      <= trial_nxt;
    part_r       <= part_nxt;
    quo_r        <= quo_nxt;
    step_r       <= step_nxt;
    fac_r        <= fac_nxt;
    pend_fac_r   <= pend_fac_nxt;
    pend_none_r  <= pend_none_nxt;
    out_factor_r <= out_factor_nxt;
    out_last_r   <= out_last_nxt;
    out_none_r   <= out_none_nxt;
  end

  // Partial remainder always stays below the divisor
  a_part_below_trial: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (part_r < trial_r))
    else $error("divider partial remainder not below divisor");

  // Divide runs its full length before evaluation
  a_div_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r != STEP_W'(W - 1)) |=> (state_r == ST_DIV))
    else $error("divide left early");

  // Result count never passes the cap
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r <= count_t'(RESULT_CAP)))
    else $error("result count above cap");

  // Flushing puts a last word in the output register and frees the input
  a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && slot_free) |=> (out_valid_r && out_last_r && state_r == ST_IDLE))
    else $error("flush did not deliver a last word");

  // A held factor is always present when flushing
  a_flush_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH) |-> pend_v_r)
    else $error("flush without a held factor");

endmodule
